/* src/fixed_command_frame_parser_defines.svh */
// Assertion macros for the fixed command frame parser.
// Used by the top level; expects signals clk and rst in scope.
`ifndef FIXED_COMMAND_FRAME_PARSER_DEFINES_SVH
`define FIXED_COMMAND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FCFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcfp assertion failed");

// Next-cycle implication, checked outside reset.
`define FCFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcfp assertion failed");

`endif

/* src/fcfp_pkg.sv */
// Shared types and constants for the fixed command frame parser.
// No dependencies; imported by every module of the block.
package fcfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned RESULT_W   = BYTE_W + WORD_W;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hA5;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h49;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 8'd1;

  // Frame position: which byte the next accepted item is.
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_COMMAND  = 3'd1,
    ST_DATA0    = 3'd2,
    ST_DATA1    = 3'd3,
    ST_DATA2    = 3'd4,
    ST_DATA3    = 3'd5,
    ST_CHECKSUM = 3'd6,
    ST_TAIL     = 3'd7
  } frame_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic [BYTE_W-1:0] command;
  } result_t;

  typedef struct packed {
    frame_state_t state;
    logic         frame_ok;
  } frame_status_t;

endpackage

/* src/fixed_command_frame_parser.sv */
// Fixed command frame parser, top level.
// Depends on fcfp_pkg, fcfp_frame, fcfp_out_buf and the assertion header.
// Usage:
//   s_tvalid/s_tready/s_tdata carry received bytes, one byte per item.
//   Idle until the header byte arrives; then take command, four data bytes,
//   checksum and tail (eight bytes per frame). A header byte inside a frame
//   is just a frame byte. At the tail byte the frame passes when the tail
//   matches and the 8-bit wrapping sum of header, command and data bytes
//   equals the checksum byte; a passing frame gives one item on
//   m_tvalid/m_tready/m_tdata, anything else is dropped silently.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write header_byte (index 0) and
//   tail_byte (index 1); other indexes are ignored. cfg_ready is always high.
// Throughput: one byte per cycle while s_tready is high; the only per-byte
//   work is one 8-bit add into the running sum, done in the cycle the byte is accepted.
// Result: a passing frame's item is registered into the output register, or
//   into the skid register while the output is stalled, as the tail byte is accepted.
// Reset: rst (synchronous) returns to idle, empties the output and skid
//   registers and loads header 0xA5, tail 0x49.
// Stall: while m_tready is low one more result fits in the skid register;
//   s_tready drops only when that register is occupied.
`include "fixed_command_frame_parser_defines.svh"

module fixed_command_frame_parser
  import fcfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
  // Result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [RESULT_W-1:0]  m_tdata,   // [7:0] command, [39:8] data_word
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] tail_byte;
  logic              in_accept;
  logic              res_valid;
  result_t           res;
  result_t           out_data;
  frame_status_t     status;

  // Configuration registers: always ready, unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
      tail_byte   <= TAIL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_HEADER) begin
        header_byte <= cfg_data;
      end else if (cfg_index == REG_TAIL) begin
        tail_byte <= cfg_data;
      end
    end
  end

  // Take an item whenever the output side has room for one more result.
  assign in_accept = s_tvalid && s_tready;

  fcfp_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .rx_byte     (s_tdata),
    .header_byte (header_byte),
    .tail_byte   (tail_byte),
    .res_valid   (res_valid),
    .res         (res),
    .status      (status)
  );

  // Hold the result here while the receiver stalls.
  fcfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_push  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {out_data.data_word, out_data.command};

  // A header seen while idle opens a frame.
  `FCFP_ASSERT_NEXT(a_header_opens,
    in_accept && status.state == ST_IDLE && s_tdata == header_byte,
    status.state == ST_COMMAND)
  // The tail byte always closes the frame.
  `FCFP_ASSERT_NEXT(a_tail_closes,
    in_accept && status.state == ST_TAIL, status.state == ST_IDLE)
  // After a passing frame, m_tvalid is high in the next cycle.
  `FCFP_ASSERT_NEXT(a_result_shown,
    in_accept && status.state == ST_TAIL && status.frame_ok, m_tvalid)
  // Results come only from the tail position.
  `FCFP_ASSERT_NOW(a_result_source,
    res_valid, in_accept && status.state == ST_TAIL)

endmodule

/* src/fcfp_frame.sv */
// Frame tracker: position state machine, running sum and held fields.
// Depends on fcfp_pkg.
module fcfp_frame
  import fcfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [BYTE_W-1:0]  rx_byte,
  input  logic [BYTE_W-1:0]  header_byte,
  input  logic [BYTE_W-1:0]  tail_byte,
  output logic               res_valid,
  output result_t            res,
  output frame_status_t      status
);

  frame_state_t      state, state_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [BYTE_W-1:0] held_command;
  logic [WORD_W-1:0] held_data;
  logic [BYTE_W-1:0] held_checksum;
  logic              frame_ok;

  assign frame_ok = (rx_byte == tail_byte) && (running_sum == held_checksum);

  // Next state.
  always_comb begin
    state_next = state;
    if (accept) begin
      unique case (state)
        ST_IDLE:     state_next = (rx_byte == header_byte) ? ST_COMMAND : ST_IDLE;
        ST_COMMAND:  state_next = ST_DATA0;
        ST_DATA0:    state_next = ST_DATA1;
        ST_DATA1:    state_next = ST_DATA2;
        ST_DATA2:    state_next = ST_DATA3;
        ST_DATA3:    state_next = ST_CHECKSUM;
        ST_CHECKSUM: state_next = ST_TAIL;
        ST_TAIL:     state_next = ST_IDLE;
        default:     state_next = ST_IDLE;
      endcase
    end
  end

  // Outputs: sum update and result strobe.
  always_comb begin
    running_sum_next = running_sum;
    res_valid        = 1'b0;
    if (accept) begin
      unique case (state)
        ST_IDLE:     running_sum_next = rx_byte;
        ST_COMMAND,
        ST_DATA0,
        ST_DATA1,
        ST_DATA2,
        ST_DATA3:    running_sum_next = running_sum + rx_byte;
        ST_CHECKSUM: running_sum_next = running_sum;
        ST_TAIL: begin
          running_sum_next = '0;
          res_valid        = frame_ok;
        end
        default:     running_sum_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      running_sum <= '0;
    end else begin
      state       <= state_next;
      running_sum <= running_sum_next;
    end
  end

  // Capture frame fields; each lands in its own lane.
  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (state)
        ST_COMMAND:  held_command        <= rx_byte;
        ST_DATA0:    held_data[7:0]      <= rx_byte;
        ST_DATA1:    held_data[15:8]     <= rx_byte;
        ST_DATA2:    held_data[23:16]    <= rx_byte;
        ST_DATA3:    held_data[31:24]    <= rx_byte;
        ST_CHECKSUM: held_checksum       <= rx_byte;
        ST_IDLE,
        ST_TAIL:     held_checksum       <= held_checksum;
        default:     held_checksum       <= held_checksum;
      endcase
    end
  end

  assign res.command   = held_command;
  assign res.data_word = held_data;

  assign status.state    = state;
  assign status.frame_ok = frame_ok;

endmodule

/* src/fcfp_out_buf.sv */
// Result register with a skid stage so input keeps flowing under stall.
// Depends on fcfp_pkg.
module fcfp_out_buf
  import fcfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t skid_data;
  logic    skid_valid;

  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_ready || !out_valid) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= push;
        end else begin
          out_valid  <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload moves with the valid bits above.
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= push_data;
      end else begin
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

/* verif/fcfp_checker.sv */
// Checker for the fixed command frame parser: watches the byte, result and
// configuration channels, tracks frames as they arrive and compares results.
// Depends on fcfp_pkg for widths, register indexes and the frame position enum.
module fcfp_checker
  import fcfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [RESULT_W-1:0]  m_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output int unsigned          fail_count,
  output int unsigned          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] tail_byte;
  frame_state_t      position;
  logic [BYTE_W-1:0] frame_sum;
  logic [BYTE_W-1:0] frame_command;
  logic [WORD_W-1:0] frame_data;
  logic [BYTE_W-1:0] frame_checksum;
  result_t           frames_due[$];

  initial begin
    fail_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Advance the frame tracker by one byte; queue a result on a passing tail.
  task automatic take_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    case (position)
      ST_IDLE: begin
        if (b == header_byte) begin
          position       = ST_COMMAND;
          frame_sum      = b;
          frame_command  = '0;
          frame_data     = '0;
          frame_checksum = '0;
        end
      end
      ST_COMMAND: begin
        frame_command = b;
        frame_sum     = frame_sum + b;
        position      = ST_DATA0;
      end
      ST_DATA0, ST_DATA1, ST_DATA2, ST_DATA3: begin
        frame_data[BYTE_W*(position - ST_DATA0) +: BYTE_W] = b;
        frame_sum = frame_sum + b;
        position  = frame_state_t'(position + 3'd1);
      end
      ST_CHECKSUM: begin
        frame_checksum = b;
        position       = ST_TAIL;
      end
      default: begin
        if (b == tail_byte && frame_sum == frame_checksum) begin
          r.command   = frame_command;
          r.data_word = frame_data;
          frames_due.push_back(r);
        end
        position  = ST_IDLE;
        frame_sum = '0;
      end
    endcase
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (frames_due.size() == 0) begin
      report_mismatch($sformatf("result cmd %h data %h with no frame due",
                                got.command, got.data_word));
    end else begin
      want = frames_due.pop_front();
      if (got.command !== want.command)
        report_mismatch($sformatf("command expected %h got %h", want.command, got.command));
      if (got.data_word !== want.data_word)
        report_mismatch($sformatf("data_word expected %h got %h",
                                  want.data_word, got.data_word));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      header_byte    = HEADER_RESET;
      tail_byte      = TAIL_RESET;
      position       = ST_IDLE;
      frame_sum      = '0;
      frame_command  = '0;
      frame_data     = '0;
      frame_checksum = '0;
      frames_due.delete();
    end else begin
      if (m_tvalid && m_tready) check_result(result_t'(m_tdata));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HEADER) header_byte = cfg_data;
        else if (cfg_index == REG_TAIL) tail_byte = cfg_data;
      end
      if (s_tvalid && s_tready) take_byte(s_tdata);
    end
    pending <= frames_due.size();
  end

endmodule

/* verif/fixed_command_frame_parser_tb.sv */
// Testbench top for the fixed command frame parser: clock, reset, byte and
// configuration stimulus, result back-pressure, watchdog and verdict.
// Depends on fcfp_pkg, the parser RTL and fcfp_checker.
module fixed_command_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fcfp_pkg::*;

  // Quiet cycles allowed before the run is called hung; covers the long hold.
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_BYTES  = 260;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 20;

  typedef enum {FRAME_GOOD, FRAME_BAD_TAIL, FRAME_BAD_SUM, FRAME_CUT} frame_kind_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata;   // [7:0] rx_byte
  logic                 m_tvalid;
  logic                 m_tready;
  logic [RESULT_W-1:0]  m_tdata;   // [7:0] command, [39:8] data_word
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned quiet_cycles;

  // Stimulus-side copy of the registers, used to build frames.
  logic [BYTE_W-1:0] cur_header;
  logic [BYTE_W-1:0] cur_tail;
  bit                idle_gaps_on;
  bit                hold_req;

  fixed_command_frame_parser dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fcfp_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stall bursts, open stretches, and one long hold on
  // request so the skid register fills and the parser stalls its input.
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_gaps_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Offer one byte, with an occasional idle burst ahead of it; hold tvalid
  // high on return so back-to-back bytes need no extra edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (idle_gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  // Leave cfg_valid as it is; the caller drops it once the writes are done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_HEADER) cur_header = val;
    else if (idx == REG_TAIL) cur_tail = val;
  endtask

  function automatic logic [CFG_IDX_W-1:0] unused_index();
    return CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, int'(REG_TAIL) + 1));
  endfunction

  // Bias toward the byte values the parser treats specially.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return cur_header;
      3:       return cur_tail;
      default: return BYTE_W'($urandom());
    endcase
  endfunction

  task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [WORD_W-1:0] data,
                            input frame_kind_t kind, output int sent);
    logic [BYTE_W-1:0] frame [8];
    logic [BYTE_W-1:0] chk;
    int n;
    chk   = cur_header + cmd + data[7:0] + data[15:8] + data[23:16] + data[31:24];
    frame = '{cur_header, cmd, data[7:0], data[15:8], data[23:16], data[31:24], chk, cur_tail};
    // Flip at least one bit so the damaged byte can never match by chance.
    if (kind == FRAME_BAD_TAIL) frame[7] ^= BYTE_W'($urandom_range(255, 1));
    if (kind == FRAME_BAD_SUM)  frame[6] ^= BYTE_W'($urandom_range(255, 1));
    n = (kind == FRAME_CUT) ? $urandom_range(7, 1) : 8;
    for (int i = 0; i < n; i++) send_byte(frame[i]);
    sent = n;
  endtask

  // Mostly well-formed frames with random content; the rest is stray bytes,
  // damaged tails and checksums, and frames cut short.
  task automatic random_frames(input int target, input bit with_hold);
    int done;
    int sent;
    int roll;
    frame_kind_t kind;
    done = 0;
    while (done < target) begin
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) send_byte(pick_byte());
      roll = $urandom_range(0, 9);
      kind = (roll < 7) ? FRAME_GOOD : (roll == 7) ? FRAME_BAD_TAIL :
             (roll == 8) ? FRAME_BAD_SUM : FRAME_CUT;
      send_frame(pick_byte(), {pick_byte(), pick_byte(), pick_byte(), pick_byte()}, kind, sent);
      done += sent;
      if (with_hold && done >= target / 2) begin
        hold_req  = 1'b1;
        with_hold = 1'b0;
      end
    end
  endtask

  // Stop the byte stream, let every due result drain, then rewrite both
  // registers with a stray write to an unused index ahead of them.
  task automatic reconfigure(input logic [BYTE_W-1:0] header, input logic [BYTE_W-1:0] tail);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(unused_index(), BYTE_W'($urandom()));
    write_reg(REG_HEADER, header);
    write_reg(REG_TAIL, tail);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [BYTE_W-1:0] h;
    int sent;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    idle_gaps_on = 1'b1;
    hold_req     = 1'b0;
    cur_header   = HEADER_RESET;
    cur_tail     = TAIL_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A write to an unused index must leave the reset values in place.
    write_reg(unused_index(), BYTE_W'($urandom()));
    cfg_valid <= 1'b0;

    // Directed: a stray byte while idle, the header byte as command and data
    // inside a frame, all-ones fields, and a checksum that does not match.
    send_byte(8'h00);
    send_frame(HEADER_RESET, {8'h00, HEADER_RESET, 8'hFF, 8'h00}, FRAME_GOOD, sent);
    send_frame(8'hFF, 32'hFFFF_FFFF, FRAME_GOOD, sent);
    send_frame(8'h00, 32'h0000_0000, FRAME_BAD_SUM, sent);

    // Reset settings, with the long output hold midway.
    random_frames(PHASE_BYTES, 1'b1);

    reconfigure(8'h00, 8'hFF);
    random_frames(PHASE_BYTES, 1'b0);

    reconfigure(8'hFF, 8'h00);
    random_frames(PHASE_BYTES, 1'b0);

    // Header and tail share one value.
    h = BYTE_W'($urandom());
    reconfigure(h, h);
    random_frames(PHASE_BYTES, 1'b0);

    // Last stretch at full rate on both sides.
    reconfigure(BYTE_W'($urandom()), BYTE_W'($urandom()));
    idle_gaps_on = 1'b0;
    random_frames(PHASE_BYTES, 1'b0);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
